[design/b85d_pkg.sv]
// ----------------------------------------------------------------------------
// b85d_pkg: shared types and constants for the base85 decoder
// Item structs, sequencer states, multiply-add unit opcodes and the
// character-to-digit lookup for the custom 85-symbol alphabet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b85d_pkg;

  localparam int unsigned RADIX       = 85;
  localparam int unsigned DIGIT_W     = 7;
  localparam int unsigned ACC_W       = 33;  // holds up to 85^5 - 1
  localparam logic [DIGIT_W-1:0] PAD_DIGIT     = 7'd84;
  localparam logic [DIGIT_W-1:0] DIGIT_INVALID = 7'd127;

  localparam logic [RADIX*8-1:0] ALPHABET =
    "!w#$x&y()*+z-{/0123456789:|<}>?@ABCDEFGHIJKLMNOPQRSTUVWXYZ[~]^_abcdefghijklmnopqrstuv";

  localparam logic [1:0] ERR_INVALID_CHAR = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW     = 2'd1;
  localparam logic [1:0] ERR_LONE_TAIL    = 2'd2;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_string;
  } b85d_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_output;
    logic       error;
    logic [1:0] error_kind;
  } b85d_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_PAD,
    S_CHECK,
    S_EMIT,
    S_ERR
  } b85d_state_t;

  typedef enum logic [1:0] {
    MAC_HOLD,
    MAC_CLEAR,
    MAC_STEP
  } b85d_mac_op_t;

  typedef struct packed {
    b85d_mac_op_t       op;
    logic [DIGIT_W-1:0] digit;
  } b85d_mac_ctl_t;

  // Position of the character in the alphabet, or DIGIT_INVALID.
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [7:0] c);
    logic [DIGIT_W-1:0] d;
    d = DIGIT_INVALID;
    for (int i = RADIX - 1; i >= 0; i--) begin
      if (ALPHABET[(RADIX-1-i)*8 +: 8] == c) begin
        d = DIGIT_W'(i);
      end
    end
    return d;
  endfunction

endpackage

`default_nettype wire

[design/base85_custom_alphabet_decoder.sv]
// A non-final character is accepted in S_IDLE, then added by one multiply-add in S_MAC.
// A fifth digit adds a range check and four output bytes;
// a final tail of k digits adds 5-k pad multiply-adds, a range check, k-1 output bytes.
// A character is taken only once the last is done; output stalls hold the sequencer.
// Synchronous active-high reset clears the group, digit count and drop flag.
// ----------------------------------------------------------------------------
// base85_custom_alphabet_decoder: top level
// Sequencer around the shared multiply-add unit; emits decoded bytes and at most one
// error item per string, decoded combinationally from the registered state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module base85_custom_alphabet_decoder
  import b85d_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire b85d_in_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output b85d_out_t      out_item
);

  b85d_state_t        state, state_next;
  logic [DIGIT_W-1:0] digit, digit_next;
  logic               eos, eos_next;
  logic [2:0]         digits_held, digits_held_next;
  logic [1:0]         last_idx, last_idx_next;
  logic               last_flag, last_flag_next;
  logic [1:0]         byte_idx, byte_idx_next;
  logic               dropping, dropping_next;
  logic [1:0]         kind, kind_next;

  b85d_mac_ctl_t      mac_ctl;
  logic [ACC_W-1:0]   acc;
  logic [DIGIT_W-1:0] in_digit;
  logic               accept;

  b85d_mac u_mac (
    .clk (clk),
    .rst (rst),
    .ctl (mac_ctl),
    .acc (acc)
  );

  assign in_digit = digit_of(in_item.in_char);
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      digits_held <= '0;
      dropping    <= 1'b0;
      byte_idx    <= '0;
    end else begin
      state       <= state_next;
      digits_held <= digits_held_next;
      dropping    <= dropping_next;
      byte_idx    <= byte_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    digit     <= digit_next;
    eos       <= eos_next;
    last_idx  <= last_idx_next;
    last_flag <= last_flag_next;
    kind      <= kind_next;
  end

  always_comb begin
    state_next       = state;
    digit_next       = digit;
    eos_next         = eos;
    digits_held_next = digits_held;
    last_idx_next    = last_idx;
    last_flag_next   = last_flag;
    byte_idx_next    = byte_idx;
    dropping_next    = dropping;
    kind_next        = kind;
    mac_ctl.op       = MAC_HOLD;
    mac_ctl.digit    = digit;
    out_valid        = 1'b0;
    out_item         = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          digit_next = in_digit;
          eos_next   = in_item.end_of_string;
          if (dropping) begin
            // drop characters until the end of the string
            if (in_item.end_of_string) begin
              dropping_next    = 1'b0;
              digits_held_next = '0;
              mac_ctl.op       = MAC_CLEAR;
            end
          end else if (in_digit == DIGIT_INVALID) begin
            kind_next  = ERR_INVALID_CHAR;
            state_next = S_ERR;
          end else begin
            state_next = S_MAC;
          end
        end
      end

      S_MAC: begin
        mac_ctl.op       = MAC_STEP;
        digits_held_next = digits_held + 3'd1;
        if (digits_held >= 3'd4) begin
          last_idx_next  = 2'd3;
          last_flag_next = eos;
          state_next     = S_CHECK;
        end else if (!eos) begin
          state_next = S_IDLE;
        end else if (digits_held == 3'd0) begin
          kind_next  = ERR_LONE_TAIL;
          state_next = S_ERR;
        end else begin
          // tail of k digits yields k-1 bytes
          last_idx_next  = digits_held[1:0] - 2'd1;
          last_flag_next = 1'b1;
          state_next     = S_PAD;
        end
      end

      S_PAD: begin
        mac_ctl.op       = MAC_STEP;
        mac_ctl.digit    = PAD_DIGIT;
        digits_held_next = digits_held + 3'd1;
        if (digits_held == 3'd4) begin
          state_next = S_CHECK;
        end
      end

      S_CHECK: begin
        byte_idx_next = '0;
        if (acc[ACC_W-1]) begin
          kind_next  = ERR_OVERFLOW;
          state_next = S_ERR;
        end else begin
          state_next = S_EMIT;
        end
      end

      S_EMIT: begin
        out_valid              = 1'b1;
        out_item.out_byte      = 8'(acc[31:0] >> {2'(2'd3 - byte_idx), 3'b000});
        out_item.end_of_output = last_flag && (byte_idx == last_idx);
        if (!out_stall) begin
          byte_idx_next = byte_idx + 2'd1;
          if (byte_idx == last_idx) begin
            mac_ctl.op       = MAC_CLEAR;
            digits_held_next = '0;
            state_next       = S_IDLE;
          end
        end
      end

      S_ERR: begin
        out_valid              = 1'b1;
        out_item.end_of_output = 1'b1;
        out_item.error         = 1'b1;
        out_item.error_kind    = kind;
        if (!out_stall) begin
          mac_ctl.op       = MAC_CLEAR;
          digits_held_next = '0;
          dropping_next    = !eos;
          state_next       = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // the digit count never passes four while waiting for a character
  assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> digits_held <= 3'd4)
    else $error("digit count out of range while idle");

  // a dropped character never starts any arithmetic
  assert property (@(posedge clk) disable iff (rst)
    accept && dropping |=> state == S_IDLE)
    else $error("dropped item left idle state");

  // data bytes never come out while dropping
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.error |-> !dropping)
    else $error("data item emitted while dropping");

  // a group that ends its output leaves the accumulator and count cleared
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> state != S_IDLE || (acc == '0 && digits_held == 3'd0)
      || $past(state) == S_EMIT && $past(byte_idx) != $past(last_idx))
    else $error("group state not cleared after output");

endmodule

`default_nettype wire

[design/b85d_mac.sv]
// ----------------------------------------------------------------------------
// b85d_mac: shared multiply-add unit
// Holds the group accumulator and updates it as acc * 85 + digit, one digit
// per cycle while the step opcode is given, for both real and pad digits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b85d_mac
  import b85d_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire b85d_mac_ctl_t    ctl,
  output logic [ACC_W-1:0]      acc
);

  // acc stays below 85^4 before a step, so the result fits in ACC_W bits
  logic [ACC_W-1:0] product;

  assign product = acc * ACC_W'(RADIX) + ACC_W'(ctl.digit);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else begin
      unique case (ctl.op)
        MAC_CLEAR: acc <= '0;
        MAC_STEP:  acc <= product;
        default:   acc <= acc;
      endcase
    end
  end

endmodule

`default_nettype wire
